/* rtl/flash_log_append_controller_top_assert.svh */
// Assertion macros for the flash log append controller.
// Depends on clk and rst_n in the scope of the module that uses them.
`ifndef FLASH_LOG_APPEND_CONTROLLER_TOP_ASSERT_SVH
`define FLASH_LOG_APPEND_CONTROLLER_TOP_ASSERT_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define FLAC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition implies a consequence in the same cycle.
`define FLAC_ASSERT_IMPL(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`else
`define FLAC_ASSERT(lbl, prop, msg)
`define FLAC_ASSERT_IMPL(lbl, pre, post, msg)
`endif
`endif

/* rtl/flac_pkg.sv */
// Shared types and constants of the flash log append controller.
// No dependencies; used by flac_mod, the top module and the testbench.
`default_nettype none
package flac_pkg;

    localparam int ADDR_W      = 32;
    localparam int HANDLE_W    = 16;
    localparam int SECTOR_W    = 16;
    localparam int LEN_W       = 12;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int MAX_RESULTS = 32;
    localparam int RESULT_CNT_W = 6;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_LOGGING_ENABLE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLIGHT_NUMBER  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_SECTOR   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_SECTORS  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PACKET_BYTES   = 3'd4;

    // Directory entry is a two byte write
    localparam logic [LEN_W-1:0] DIR_ENTRY_BYTES = 12'd2;

    typedef enum logic [1:0] {
        CMD_DIR_WRITE   = 2'd0,
        CMD_ERASE       = 2'd1,
        CMD_CHUNK_WRITE = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIR,
        ST_ERASE,
        ST_READ,
        ST_MOD,
        ST_FIRST,
        ST_SECOND
    } state_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] packet_handle;
        logic                erase_done;
    } rec_item_t;

    typedef struct packed {
        cmd_t                command;
        logic [ADDR_W-1:0]   flash_address;
        logic [LEN_W-1:0]    chunk_length;
        logic [HANDLE_W-1:0] data_word;
        logic [LEN_W-1:0]    chunk_offset;
        logic                last;
    } flash_item_t;

endpackage
`default_nettype wire

/* rtl/flac_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module flac_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* rtl/flac_mod.sv */
// Registered page offset of a 32-bit address for a power-of-two page size.
// Depends on flac_pkg for the address width.
`default_nettype none
module flac_mod #(
    parameter int DIVISOR = 256,
    parameter int REM_W   = $clog2(DIVISOR)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [flac_pkg::ADDR_W-1:0] dividend,
    output logic                           done,
    output logic      [REM_W-1:0]          rem
);

    logic [REM_W-1:0]  rem_reg, rem_next;
    logic              done_reg, done_next;

    // Take the low address bits on start; the page size is a power of two
    always_comb
    begin
        done_next = start;
        if (start)
        begin
            rem_next = dividend[REM_W-1:0];
        end
        else
        begin
            rem_next = rem_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

/* rtl/flash_log_append_controller_top.sv */
// Flash log append controller: config registers, sequencer and handle ring.
// Depends on flac_pkg, flac_ram, flac_mod and the assertion macro header.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+-------------------
//  record    | in        | rec_valid / rec_stall      | rec (rec_item_t)
//  flash     | out       | flash_valid / flash_stall  | flash_cmd
//  config    | in        | cfg_write_en               | cfg_index, cfg_data
//
// A sector change holds rec_stall through the check, directory write and erase
// states. A drain runs a check state, then per record: a ring RAM read that also
// registers the page offset, a split state, then one or two command states.
// flash_stall on a full output register holds the command state. Reset leaves
// the ring RAM undefined; no clearing pass is run. rec_stall stays high until
// every command of the record has gone to the output register.
`default_nettype none
module flash_log_append_controller_top #(
    parameter int SECTOR_BYTES   = 4096,
    parameter int PAGE_BYTES     = 256,
    parameter int RING_DEPTH     = 16,
    parameter int METADATA_PAGES = 2
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              rec_valid,
    output logic                                   rec_stall,
    input  wire flac_pkg::rec_item_t               rec,
    output logic                                   flash_valid,
    input  wire logic                              flash_stall,
    output flac_pkg::flash_item_t                  flash_cmd,
    input  wire logic                              cfg_write_en,
    input  wire logic [flac_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [flac_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import flac_pkg::*;
    `include "flash_log_append_controller_top_assert.svh"

    localparam int HEAD_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W   = $clog2(RING_DEPTH + 1);
    localparam int PSUM_W  = CNT_W + 1;
    localparam int LIM_W   = SECTOR_W + 1 + $clog2(SECTOR_BYTES + 1);
    localparam int CMP_W   = (LIM_W > ADDR_W) ? LIM_W : ADDR_W;
    localparam int REM_W   = $clog2(PAGE_BYTES);
    localparam int OFF_W   = (REM_W > LEN_W) ? REM_W : LEN_W;
    localparam logic [ADDR_W-1:0] META_BYTES = ADDR_W'(METADATA_PAGES * PAGE_BYTES);
    localparam logic [ADDR_W-1:0] SECTOR_SIZE = ADDR_W'(SECTOR_BYTES);

    // Configuration registers
    logic                logging_enable_reg;
    logic [HANDLE_W-1:0] flight_number_reg;
    logic [SECTOR_W-1:0] total_sectors_reg;
    logic [LEN_W-1:0]    packet_bytes_reg;

    // Control state
    state_t              state_reg, state_next;
    logic [SECTOR_W-1:0] sector_reg, sector_next;
    logic [ADDR_W-1:0]   waddr_reg, waddr_next;
    logic                erase_busy_reg, erase_busy_next;
    logic [HEAD_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [RESULT_CNT_W-1:0] n_reg, n_next;
    logic                out_valid_reg, out_valid_next;

    // Datapath registers
    logic [LIM_W-1:0]    limit_reg, limit_next;
    logic [LEN_W-1:0]    first_reg, first_next;
    logic [LEN_W-1:0]    second_reg, second_next;
    flash_item_t         out_reg, out_next;

    // Combinational helpers
    logic                accept, active, slot_free, load_out, more;
    logic [PSUM_W-1:0]   head_plus, tail_sum;
    logic [HEAD_W-1:0]   head_inc, head_eff, tail;
    logic [CNT_W-1:0]    count_eff, count_dec;
    logic [RESULT_CNT_W-1:0] n_inc;
    logic [ADDR_W-1:0]   end_addr;
    logic [OFF_W-1:0]    rem_ext;
    logic                ram_we, ram_re;
    logic [HANDLE_W-1:0] ram_rdata;
    logic                mod_start, mod_done;
    logic [REM_W-1:0]    mod_rem;

    assign accept    = rec_valid && !rec_stall;
    assign active    = logging_enable_reg && (sector_reg < total_sectors_reg);
    assign slot_free = !out_valid_reg || !flash_stall;
    assign end_addr  = waddr_reg + ADDR_W'(packet_bytes_reg);
    assign rem_ext   = OFF_W'(mod_rem);
    assign n_inc     = n_reg + RESULT_CNT_W'(1);

    // Ring pointer arithmetic: wrap at the ring depth
    always_comb
    begin
        head_plus = PSUM_W'(head_reg) + PSUM_W'(1);
        if (head_plus >= PSUM_W'(RING_DEPTH))
        begin
            head_inc = '0;
        end
        else
        begin
            head_inc = HEAD_W'(head_plus);
        end
        if (count_reg >= CNT_W'(RING_DEPTH))
        begin
            head_eff  = head_inc;
            count_eff = CNT_W'(RING_DEPTH - 1);
        end
        else
        begin
            head_eff  = head_reg;
            count_eff = count_reg;
        end
        tail_sum = PSUM_W'(head_eff) + PSUM_W'(count_eff);
        if (tail_sum >= PSUM_W'(RING_DEPTH))
        begin
            tail = HEAD_W'(tail_sum - PSUM_W'(RING_DEPTH));
        end
        else
        begin
            tail = HEAD_W'(tail_sum);
        end
        count_dec = count_reg - CNT_W'(1);
    end

    // Sequencer: next state and command generation
    always_comb
    begin
        state_next      = state_reg;
        sector_next     = sector_reg;
        waddr_next      = waddr_reg;
        erase_busy_next = erase_busy_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        n_next          = n_reg;
        limit_next      = limit_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        out_next        = out_reg;
        load_out        = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        mod_start       = 1'b0;
        more            = 1'b0;
        rec_stall       = (state_reg != ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                // Store the handle, then either track the erase or start work
                if (accept && active)
                begin
                    ram_we     = 1'b1;
                    head_next  = head_eff;
                    count_next = count_eff + CNT_W'(1);
                    if (erase_busy_reg)
                    begin
                        erase_busy_next = !rec.erase_done;
                    end
                    else
                    begin
                        limit_next = (LIM_W'(sector_reg) + LIM_W'(1)) * LIM_W'(SECTOR_BYTES);
                        n_next     = '0;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                // Record end at or beyond the end of this sector: advance to the next one
                if (CMP_W'(end_addr) >= CMP_W'(limit_reg))
                begin
                    sector_next = sector_reg + SECTOR_W'(1);
                    state_next  = ST_DIR;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_DIR:
            begin
                if (slot_free)
                begin
                    load_out               = 1'b1;
                    out_next.command       = CMD_DIR_WRITE;
                    out_next.flash_address = ADDR_W'({sector_reg, 1'b0});
                    out_next.chunk_length  = DIR_ENTRY_BYTES;
                    out_next.data_word     = flight_number_reg;
                    out_next.chunk_offset  = '0;
                    out_next.last          = 1'b0;
                    state_next             = ST_ERASE;
                end
            end
            ST_ERASE:
            begin
                if (slot_free)
                begin
                    load_out               = 1'b1;
                    out_next.command       = CMD_ERASE;
                    out_next.flash_address = ADDR_W'(sector_reg) * SECTOR_SIZE;
                    out_next.chunk_length  = '0;
                    out_next.data_word     = '0;
                    out_next.chunk_offset  = '0;
                    out_next.last          = 1'b1;
                    erase_busy_next        = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            ST_READ:
            begin
                // Fetch the oldest handle and start the page remainder
                ram_re     = 1'b1;
                mod_start  = 1'b1;
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                // Split at the page holding the record end
                if (mod_done)
                begin
                    if (rem_ext >= OFF_W'(packet_bytes_reg))
                    begin
                        second_next = '0;
                    end
                    else
                    begin
                        second_next = LEN_W'(rem_ext);
                    end
                    first_next = packet_bytes_reg - second_next;
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                if (slot_free)
                begin
                    more = (count_dec != '0) && (n_inc <= RESULT_CNT_W'(MAX_RESULTS - 2));
                    load_out               = 1'b1;
                    out_next.command       = CMD_CHUNK_WRITE;
                    out_next.flash_address = waddr_reg;
                    out_next.chunk_length  = first_reg;
                    out_next.data_word     = ram_rdata;
                    out_next.chunk_offset  = '0;
                    out_next.last          = (second_reg == '0) && !more;
                    head_next              = head_inc;
                    count_next             = count_dec;
                    n_next                 = n_inc;
                    if (second_reg == '0)
                    begin
                        waddr_next = end_addr;
                        state_next = more ? ST_READ : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SECOND;
                    end
                end
            end
            ST_SECOND:
            begin
                if (slot_free)
                begin
                    more = (count_reg != '0) && (n_inc <= RESULT_CNT_W'(MAX_RESULTS - 2));
                    load_out               = 1'b1;
                    out_next.command       = CMD_CHUNK_WRITE;
                    out_next.flash_address = waddr_reg + ADDR_W'(first_reg);
                    out_next.chunk_length  = second_reg;
                    out_next.data_word     = ram_rdata;
                    out_next.chunk_offset  = first_reg;
                    out_next.last          = !more;
                    n_next                 = n_inc;
                    waddr_next             = end_addr;
                    state_next             = more ? ST_READ : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A start sector write reloads the position
        if (cfg_write_en && (cfg_index == CFG_START_SECTOR))
        begin
            sector_next = cfg_data;
            waddr_next  = ADDR_W'(cfg_data) * SECTOR_SIZE + META_BYTES;
        end

        // Output register: load on a new command, drop after transfer
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!flash_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sector_reg     <= SECTOR_W'(1);
            waddr_reg      <= SECTOR_SIZE + META_BYTES;
            erase_busy_reg <= 1'b0;
            head_reg       <= '0;
            count_reg      <= '0;
            n_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sector_reg     <= sector_next;
            waddr_reg      <= waddr_next;
            erase_busy_reg <= erase_busy_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            n_reg          <= n_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            logging_enable_reg <= 1'b0;
            flight_number_reg  <= '0;
            total_sectors_reg  <= SECTOR_W'(1024);
            packet_bytes_reg   <= LEN_W'(200);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_LOGGING_ENABLE: logging_enable_reg <= cfg_data[0];
                CFG_FLIGHT_NUMBER:  flight_number_reg  <= cfg_data;
                CFG_TOTAL_SECTORS:  total_sectors_reg  <= cfg_data;
                CFG_PACKET_BYTES:   packet_bytes_reg   <= cfg_data[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        limit_reg  <= limit_next;
        first_reg  <= first_next;
        second_reg <= second_next;
        out_reg    <= out_next;
    end

    assign flash_valid = out_valid_reg;
    assign flash_cmd   = out_reg;

    // Handle ring storage
    flac_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail),
        .wdata (rec.packet_handle),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // Page remainder of the record end address
    flac_mod #(
        .DIVISOR (PAGE_BYTES)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (end_addr),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // Assertions
    `FLAC_ASSERT(a_count_bound, count_reg <= CNT_W'(RING_DEPTH), "ring count above depth")
    `FLAC_ASSERT(a_result_budget, n_reg <= RESULT_CNT_W'(MAX_RESULTS), "result budget exceeded")
    `FLAC_ASSERT_IMPL(a_no_overrun, load_out, !(out_valid_reg && flash_stall), "output overrun")
    `FLAC_ASSERT_IMPL(a_erase_start, $rose(erase_busy_reg), $past(state_reg == ST_ERASE), "erase flag set outside erase")
    `FLAC_ASSERT_IMPL(a_mod_wait, mod_done, state_reg == ST_MOD, "remainder done outside wait")

endmodule
`default_nettype wire

/* tb/sv/append_log_tb_pkg.sv */
// Expected-command tracker for the flash log append controller testbench.
// Depends on flac_pkg for the payload structs, command codes and register indexes.
package append_log_tb_pkg;
    import flac_pkg::*;

    localparam int unsigned SECTOR_BYTES   = 4096;
    localparam int unsigned PAGE_BYTES     = 256;
    localparam int unsigned RING_DEPTH     = 16;
    localparam int unsigned METADATA_PAGES = 2;

    class append_log_scoreboard;
        // register copies
        bit                  log_on;
        bit [15:0]           flight;
        bit [15:0]           first_sector;
        bit [15:0]           sector_limit;
        bit [LEN_W-1:0]      record_bytes;
        // write position, erase flag and handle ring
        bit [SECTOR_W-1:0]   sector;
        bit [ADDR_W-1:0]     wr_addr;
        bit                  erase_pending;
        bit [HANDLE_W-1:0]   handles [RING_DEPTH];
        int unsigned         head;
        int unsigned         count;
        flash_item_t         pending_cmds [$];
        int unsigned         fail_count;

        function new();
            log_on        = 1'b0;
            flight        = '0;
            first_sector  = 16'd1;
            sector_limit  = 16'd1024;
            record_bytes  = 12'd200;
            erase_pending = 1'b0;
            head          = 0;
            count         = 0;
            fail_count    = 0;
            reload_position();
        endfunction

        // restart the write position at the metadata end of the first sector
        function void reload_position();
            sector  = first_sector;
            wr_addr = first_sector * SECTOR_BYTES + METADATA_PAGES * PAGE_BYTES;
        endfunction

        function void set_register(bit [CFG_INDEX_W-1:0] index, bit [CFG_DATA_W-1:0] data);
            case (index)
                CFG_LOGGING_ENABLE: log_on = data[0];
                CFG_FLIGHT_NUMBER:  flight = data;
                CFG_START_SECTOR:
                begin
                    first_sector = data;
                    reload_position();
                end
                CFG_TOTAL_SECTORS:  sector_limit = data;
                CFG_PACKET_BYTES:   record_bytes = data[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function void queue_cmd(cmd_t op, bit [ADDR_W-1:0] addr, bit [LEN_W-1:0] len,
                                bit [HANDLE_W-1:0] word, bit [LEN_W-1:0] offset);
            flash_item_t cmd;
            cmd.command       = op;
            cmd.flash_address = addr;
            cmd.chunk_length  = len;
            cmd.data_word     = word;
            cmd.chunk_offset  = offset;
            cmd.last          = 1'b0;
            pending_cmds.push_back(cmd);
        endfunction

        // Work out the commands one accepted record causes; return 0 if it is dropped.
        function bit note_record(rec_item_t item);
            bit [ADDR_W-1:0] end_addr;
            bit [ADDR_W-1:0] tail_bytes;
            bit [ADDR_W-1:0] lead_bytes;
            int              results;
            flash_item_t     final_cmd;

            // drop while logging is off or the flash is full
            if (!log_on || sector >= sector_limit)
                return 1'b0;
            // push the handle, overwriting the oldest one when the ring is full
            if (count >= RING_DEPTH)
            begin
                head  = (head + 1) % RING_DEPTH;
                count = RING_DEPTH - 1;
            end
            handles[(head + count) % RING_DEPTH] = item.packet_handle;
            count++;
            // only watch the erase status while an erase is pending
            if (erase_pending)
            begin
                erase_pending = !item.erase_done;
                return 1'b1;
            end
            results  = 0;
            end_addr = wr_addr + record_bytes;
            if (end_addr / SECTOR_BYTES > sector)
            begin
                // advance the sector: directory entry, then erase
                sector = sector + 1'b1;
                queue_cmd(CMD_DIR_WRITE, sector * 32'd2, DIR_ENTRY_BYTES, flight, '0);
                queue_cmd(CMD_ERASE, sector * SECTOR_BYTES, '0, '0, '0);
                erase_pending = 1'b1;
                results = 2;
            end
            else
            begin
                // drain the ring, splitting each record at the page holding its end
                while (count > 0 && results <= MAX_RESULTS - 2)
                begin
                    end_addr   = wr_addr + record_bytes;
                    tail_bytes = end_addr % PAGE_BYTES;
                    if (tail_bytes >= record_bytes)
                        tail_bytes = '0;
                    lead_bytes = record_bytes - tail_bytes;
                    queue_cmd(CMD_CHUNK_WRITE, wr_addr, lead_bytes[LEN_W-1:0],
                              handles[head], '0);
                    results++;
                    if (tail_bytes != 0)
                    begin
                        queue_cmd(CMD_CHUNK_WRITE, wr_addr + lead_bytes,
                                  tail_bytes[LEN_W-1:0], handles[head],
                                  lead_bytes[LEN_W-1:0]);
                        results++;
                    end
                    head    = (head + 1) % RING_DEPTH;
                    count--;
                    wr_addr = end_addr;
                end
            end
            // flag the final command of this record
            if (results > 0)
            begin
                final_cmd      = pending_cmds.pop_back();
                final_cmd.last = 1'b1;
                pending_cmds.push_back(final_cmd);
            end
            return 1'b1;
        endfunction

        function void compare_field(string name, logic [ADDR_W-1:0] want,
                                    logic [ADDR_W-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                fail_count++;
            end
        endfunction

        // Compare one flash transfer with the oldest expected command.
        function void check_command(flash_item_t got);
            flash_item_t want;
            if (pending_cmds.size() == 0)
            begin
                $error("flash command with nothing expected: command %0d address %0h",
                       got.command, got.flash_address);
                fail_count++;
                return;
            end
            want = pending_cmds.pop_front();
            compare_field("command", ADDR_W'(want.command), ADDR_W'(got.command));
            compare_field("flash_address", want.flash_address, got.flash_address);
            compare_field("chunk_length", ADDR_W'(want.chunk_length),
                          ADDR_W'(got.chunk_length));
            compare_field("data_word", ADDR_W'(want.data_word), ADDR_W'(got.data_word));
            compare_field("chunk_offset", ADDR_W'(want.chunk_offset),
                          ADDR_W'(got.chunk_offset));
            compare_field("last", ADDR_W'(want.last), ADDR_W'(got.last));
        endfunction

        function int unsigned pending();
            return pending_cmds.size();
        endfunction
    endclass

endpackage

/* tb/sv/tb_flash_log_append_controller_top.sv */
// Top of the flash log append controller testbench: clock, reset, drivers and the run.
// Depends on flac_pkg, append_log_tb_pkg and flash_log_append_controller_top.
module tb_flash_log_append_controller_top;
    timeunit 1ns;
    timeprecision 1ps;

    import flac_pkg::*;
    import append_log_tb_pkg::*;

    localparam int RANDOM_ITEMS   = 300;
    localparam int SETTLE_CYCLES  = 64;
    localparam int TAIL_CYCLES    = 100;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   rec_valid    = 1'b0;
    logic                   rec_stall;
    rec_item_t              rec          = '0;
    logic                   flash_valid;
    logic                   flash_stall  = 1'b0;
    flash_item_t            flash_cmd;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    int send_idle_pct  = 30;
    int recv_stall_pct = 72;
    int records_taken  = 0;    // records the block acted on
    int dropped_run    = 0;    // consecutive records dropped

    append_log_scoreboard sb = new();

    flash_log_append_controller_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .rec_valid    (rec_valid),
        .rec_stall    (rec_stall),
        .rec          (rec),
        .flash_valid  (flash_valid),
        .flash_stall  (flash_stall),
        .flash_cmd    (flash_cmd),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // check each flash transfer and pick the stall for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && flash_valid && !flash_stall)
            sb.check_command(flash_cmd);
        flash_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // end the run when no transfer happens for too long
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((rec_valid && !rec_stall) || (flash_valid && !flash_stall) || cfg_write_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // present one record after a random gap and hold it until the transfer
    task automatic send_record(input logic [HANDLE_W-1:0] handle, input logic done);
        rec_item_t item;
        item.packet_handle = handle;
        item.erase_done    = done;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            rec_valid <= 1'b0;
            @(posedge clk);
        end
        rec_valid <= 1'b1;
        rec       <= item;
        @(posedge clk);
        while (rec_stall)
            @(posedge clk);
        if (sb.note_record(item))
        begin
            records_taken++;
            dropped_run = 0;
        end
        else
            dropped_run++;
    endtask

    // drop valid and wait until every expected command has come out
    task automatic wait_drained();
        rec_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // drain, then let a record that caused nothing finish inside the block
    task automatic settle_block(input int cycles);
        wait_drained();
        repeat (cycles) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= index;
        cfg_data     <= data;
        @(posedge clk);
        sb.set_register(index, data);
    endtask

    // write the registers back to back; start_sector only when asked
    task automatic program_setup(input bit enable, input bit [15:0] flight, input bit reload,
                                 input bit [15:0] start, input bit [15:0] total,
                                 input bit [11:0] bytes);
        cfg_write(CFG_LOGGING_ENABLE, CFG_DATA_W'(enable));
        cfg_write(CFG_FLIGHT_NUMBER, flight);
        if (reload)
            cfg_write(CFG_START_SECTOR, start);
        cfg_write(CFG_TOTAL_SECTORS, total);
        cfg_write(CFG_PACKET_BYTES, CFG_DATA_W'(bytes));
        cfg_write_en <= 1'b0;
    endtask

    initial
    begin : stimulus
        bit [15:0] start;
        bit [15:0] total;
        bit [11:0] bytes;
        bit        enable;
        int        done_pct;
        int        span;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // logging still off after reset: dropped
        send_record(16'hFFFF, 1'b1);
        settle_block(SETTLE_CYCLES);
        // one whole chunk, then a record split at a page boundary
        program_setup(1'b1, 16'hFFFF, 1'b1, 16'd1, 16'hFFFF, 12'd200);
        send_record(16'h0000, 1'b0);
        send_record(16'hFFFF, 1'b1);
        settle_block(SETTLE_CYCLES);
        // longest record without a reload: sector change, erase wait, long chunks
        program_setup(1'b1, 16'h0000, 1'b0, 16'd0, 16'd1024, 12'hFFF);
        send_record(16'h1234, 1'b0);
        send_record(16'h5555, 1'b0);
        send_record(16'hAAAA, 1'b1);
        send_record(16'h00FF, 1'b0);
        send_record(16'h8001, 1'b1);
        send_record(16'h0001, 1'b1);
        settle_block(SETTLE_CYCLES);
        // zero-length records: the address stays put
        program_setup(1'b1, 16'h5A5A, 1'b1, 16'd3, 16'd1024, 12'd0);
        send_record(16'h7FFF, 1'b0);
        send_record(16'h8000, 1'b1);
        settle_block(SETTLE_CYCLES);
        // last sector below the limit, then the flash is full
        program_setup(1'b1, 16'hA5A5, 1'b1, 16'd65534, 16'hFFFF, 12'hFFF);
        send_record(16'h4321, 1'b0);
        send_record(16'hBCDE, 1'b1);
        settle_block(SETTLE_CYCLES);
        // a one-sector limit: full from the start
        program_setup(1'b1, 16'h0000, 1'b1, 16'd1, 16'd1, 12'd1);
        send_record(16'h0F0F, 1'b0);

        // random sessions, each with its own register setting
        records_taken = 0;
        while (records_taken < RANDOM_ITEMS)
        begin
            enable = ($urandom_range(0, 15) != 0);
            case ($urandom_range(0, 7))
                0:       start = 16'hFFFF;
                1:       start = 16'($urandom_range(1, 65535));
                default: start = 16'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 7))
                0:       total = 16'hFFFF;
                1:       total = start;
                default: total = (start > 16'hFFFC) ? 16'hFFFF
                                                    : start + 16'($urandom_range(1, 3));
            endcase
            case ($urandom_range(0, 9))
                0:       bytes = 12'd0;
                1:       bytes = 12'd1;
                2:       bytes = 12'hFFF;
                3, 4:    bytes = 12'($urandom_range(1, 4095));
                default: bytes = 12'($urandom_range(16, 600));
            endcase
            case ($urandom_range(0, 2))
                0:       done_pct = 8;
                1:       done_pct = 40;
                default: done_pct = 90;
            endcase
            settle_block(SETTLE_CYCLES);
            program_setup(enable, 16'($urandom), $urandom_range(0, 3) != 0, start, total, bytes);
            span = enable ? $urandom_range(8, 40) : 2;
            dropped_run = 0;
            while (span > 0 && dropped_run < 3)
            begin
                // swap the idle mix by progress, then run with no idling
                if (records_taken < RANDOM_ITEMS / 3)
                begin
                    send_idle_pct  = 30;
                    recv_stall_pct = 72;
                end
                else if (records_taken < 2 * RANDOM_ITEMS / 3)
                begin
                    send_idle_pct  = 72;
                    recv_stall_pct = 30;
                end
                else
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                // hold off now and then until the block has emptied
                if ($urandom_range(0, 24) == 0)
                    wait_drained();
                send_record(HANDLE_W'($urandom), $urandom_range(0, 99) < done_pct);
                span--;
            end
        end

        settle_block(TAIL_CYCLES);
        if (sb.fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* flash_log_append_controller_top.f */
+incdir+rtl
rtl/flac_pkg.sv
rtl/flac_ram.sv
rtl/flac_mod.sv
rtl/flash_log_append_controller_top.sv
tb/sv/append_log_tb_pkg.sv
tb/sv/tb_flash_log_append_controller_top.sv
